// ===== rtl/isp_pkg.sv =====
// Shared types and constants for the interpolating sample player.
package isp_pkg;

  localparam int DEF_MAX_SAMPLES = 16384;
  localparam int DEF_CHAN_LIMIT  = 2;

  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STEP            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CONNECTED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd4;

  localparam logic [19:0] STEP_RESET   = 20'h10000;
  localparam int          LENGTH_RESET = 16384;
  localparam int          LENGTH_MIN   = 16;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PS_DISABLED   = 2'd0,
    PS_ENABLED    = 2'd1,
    PS_COMPLETING = 2'd2,
    PS_COMPLETE   = 2'd3
  } play_state_t;

  typedef struct packed {
    logic               req_type;
    logic               start_req;
    logic               stop;
    logic [13:0]        load_index;
    logic               load_channel;
    logic signed [15:0] load_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         channels_out;
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic               finished_pulse;
  } out_t;

endpackage

// ===== rtl/interpolating_sample_player_core.sv =====
// Interpolating sample player: sample store, play position and output pipeline.
//
// Input channel (in_valid/in_ready/in_word): a load word writes one Q1.15
// sample into the store of its channel and gives no result. A sample word
// applies the start/stop triggers and gives exactly one result word on the
// output channel (out_valid/out_ready/out_word).
// A sample word passes the store read, then the multiply, then round and
// add into the output register, where its result holds until out_ready.
// Throughput: one word per cycle while in_ready is high, loads and samples
// mixed freely. The play position update (one add, two compares, one
// subtract) is done in the accept cycle, so the next word sees it at once.
// After a length write that shrinks the buffer to half the play position
// or less, the position wrap takes a restoring reduction; in_ready is low
// during it.
// Configuration writes (cfg_wr_en/cfg_addr/cfg_wr_data) take effect at once.
// Reset: registers take their reset values, playback is disabled at
// position zero and the pipeline is empty. The store holds no defined
// contents until written.
// Receiver stall: the output word holds; the pipeline stages behind it
// keep filling, and in_ready drops only when the first stage is full.
module interpolating_sample_player_core #(
  parameter int MAX_SAMPLES = isp_pkg::DEF_MAX_SAMPLES,
  parameter int CHAN_LIMIT  = isp_pkg::DEF_CHAN_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [isp_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  isp_pkg::in_t                    in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output isp_pkg::out_t                   out_word
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int PW = AW + 16;
  localparam int SW = AW + 18;
  localparam int K  = AW - 3;
  localparam int RW = SW + K;
  localparam int CW = $clog2(K + 1);
  localparam int LW = $clog2(MAX_SAMPLES + 1);
  localparam int LEN_RST = (isp_pkg::LENGTH_RESET > MAX_SAMPLES) ? MAX_SAMPLES
                                                                 : isp_pkg::LENGTH_RESET;

  // configuration
  logic [19:0]   step;
  logic [LW-1:0] len_eff;
  logic          loop_enable;
  logic          start_connected;
  logic [1:0]    channel_count;
  logic [31:0]   len_wr;

  assign len_wr = 32'(cfg_wr_data[14:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= isp_pkg::STEP_RESET;
      len_eff         <= LW'(LEN_RST);
      loop_enable     <= 1'b0;
      start_connected <= 1'b0;
      channel_count   <= 2'd0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        isp_pkg::REG_STEP: begin
          step <= cfg_wr_data[19:0];
        end
        isp_pkg::REG_LENGTH: begin
          if (len_wr < 32'(isp_pkg::LENGTH_MIN)) begin
            len_eff <= LW'(isp_pkg::LENGTH_MIN);
          end else if (len_wr > 32'(MAX_SAMPLES)) begin
            len_eff <= LW'(MAX_SAMPLES);
          end else begin
            len_eff <= len_wr[LW-1:0];
          end
        end
        isp_pkg::REG_LOOP_ENABLE: begin
          loop_enable <= cfg_wr_data[0];
        end
        isp_pkg::REG_START_CONNECTED: begin
          start_connected <= cfg_wr_data[0];
        end
        isp_pkg::REG_CHANNEL_COUNT: begin
          channel_count <= cfg_wr_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake and pipeline occupancy
  logic in_acc, is_load, smp_acc, ld_acc;
  logic busy;
  logic b_valid, c_valid;
  logic out_load, c_free, b_move, b_free;

  assign out_load = c_valid && (!out_valid || out_ready);
  assign c_free   = !c_valid || out_load;
  assign b_move   = b_valid && c_free;
  assign b_free   = !b_valid || b_move;
  assign in_ready = !busy && b_free;

  assign in_acc  = in_valid && in_ready;
  assign is_load = (in_word.req_type == isp_pkg::REQ_LOAD);
  assign smp_acc = in_acc && !is_load;
  assign ld_acc  = in_acc && is_load;

  // play state and position
  isp_pkg::play_state_t state, state_next, st_mid;
  logic [PW-1:0] pos, pos_next, pos_eff;
  logic [SW-1:0] r, r_next, red_r, sum, len16, sub1;
  logic [RW-1:0] d, d_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          busy_next, red_ge, playing, wrap1, wrap2, fin;
  logic [AW-1:0] i1_raw, i1, i2;
  logic [AW:0]   i1p;
  logic [1:0]    nch;

  always_comb begin
    st_mid  = state;
    pos_eff = pos;
    if (in_word.stop) begin
      if (state == isp_pkg::PS_ENABLED) begin
        st_mid = isp_pkg::PS_COMPLETING;
      end
    end else if (in_word.start_req ||
                 (!start_connected && state == isp_pkg::PS_DISABLED)) begin
      st_mid  = isp_pkg::PS_ENABLED;
      pos_eff = '0;
    end
    playing = (st_mid == isp_pkg::PS_ENABLED) || (st_mid == isp_pkg::PS_COMPLETING);

    i1_raw = pos_eff[PW-1:16];
    if (32'(i1_raw) >= 32'(MAX_SAMPLES)) begin
      i1 = AW'(MAX_SAMPLES - 1);
    end else begin
      i1 = i1_raw;
    end
    i1p = {1'b0, i1} + (AW+1)'(1);
    // next sample index wraps to zero at the buffer end
    if (32'(i1p) >= 32'(len_eff)) begin
      i2 = '0;
    end else begin
      i2 = i1p[AW-1:0];
    end

    sum   = SW'(pos_eff) + SW'(step);
    len16 = SW'({len_eff, 16'h0000});
    sub1  = sum - len16;
    wrap1 = (sum >= len16);
    wrap2 = (sum >= (len16 << 1));

    if (32'(channel_count) > 32'(CHAN_LIMIT)) begin
      nch = 2'(CHAN_LIMIT);
    end else begin
      nch = channel_count;
    end

    red_ge = (RW'(r) >= d);
    red_r  = red_ge ? SW'(RW'(r) - d) : r;

    state_next = state;
    pos_next   = pos;
    busy_next  = busy;
    r_next     = r;
    d_next     = d;
    cnt_next   = cnt;
    fin        = 1'b0;
    if (busy) begin
      // one restoring step of the position reduction
      r_next   = red_r;
      d_next   = d >> 1;
      cnt_next = cnt - CW'(1);
      pos_next = red_r[PW-1:0];
      if (cnt == CW'(1)) begin
        busy_next = 1'b0;
      end
    end else if (smp_acc) begin
      state_next = st_mid;
      pos_next   = pos_eff;
      if (playing) begin
        if (!wrap1) begin
          pos_next = sum[PW-1:0];
        end else begin
          fin = 1'b1;
          if (!loop_enable || st_mid == isp_pkg::PS_COMPLETING) begin
            state_next = isp_pkg::PS_COMPLETE;
          end
          if (!wrap2) begin
            pos_next = sub1[PW-1:0];
          end else begin
            busy_next = 1'b1;
            r_next    = sum;
            d_next    = RW'(len16) << (K - 1);
            cnt_next  = CW'(K);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isp_pkg::PS_DISABLED;
      pos   <= '0;
      busy  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      busy  <= busy_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    d <= d_next;
  end

  // sample store, one memory per channel, two read ports each
  logic signed [15:0] mem0 [MAX_SAMPLES];
  logic signed [15:0] mem1 [MAX_SAMPLES];
  logic signed [15:0] rd0a, rd0b, rd1a, rd1b;
  logic [31:0]        idx_ext;
  logic [AW-1:0]      waddr;
  logic               wr_ok;

  assign idx_ext = 32'(in_word.load_index);
  assign waddr   = idx_ext[AW-1:0];
  assign wr_ok   = ld_acc && (idx_ext < 32'(MAX_SAMPLES)) &&
                   (32'(in_word.load_channel) < 32'(CHAN_LIMIT));

  always_ff @(posedge clk) begin
    if (wr_ok && !in_word.load_channel) begin
      mem0[waddr] <= in_word.load_value;
    end
    if (smp_acc) begin
      rd0a <= mem0[i1];
      rd0b <= mem0[i2];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok && in_word.load_channel) begin
      mem1[waddr] <= in_word.load_value;
    end
    if (smp_acc) begin
      rd1a <= mem1[i1];
      rd1b <= mem1[i2];
    end
  end

  // stage B: read data plus side info
  logic [15:0] b_frac;
  logic [1:0]  b_nch;
  logic        b_play, b_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (smp_acc) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      b_frac <= pos_eff[15:0];
      b_nch  <= nch;
      b_play <= playing;
      b_fin  <= fin;
    end
  end

  // stage C: difference times fraction
  logic signed [16:0] diff0, diff1, frac_s;
  logic signed [33:0] prod0, prod1, c_prod0, c_prod1;
  logic signed [15:0] c_a0, c_a1;
  logic [1:0]         c_nch;
  logic               c_play, c_fin;

  assign diff0  = $signed({rd0b[15], rd0b}) - $signed({rd0a[15], rd0a});
  assign diff1  = $signed({rd1b[15], rd1b}) - $signed({rd1a[15], rd1a});
  assign frac_s = $signed({1'b0, b_frac});
  assign prod0  = diff0 * frac_s;
  assign prod1  = diff1 * frac_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_move) begin
      c_valid <= 1'b1;
    end else if (out_load) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_prod0 <= prod0;
      c_prod1 <= prod1;
      c_a0    <= rd0a;
      c_a1    <= rd1a;
      c_nch   <= b_nch;
      c_play  <= b_play;
      c_fin   <= b_fin;
    end
  end

  // output: round half up, add base sample, zero unused channels and all channels while not playing
  logic signed [33:0] q0, q1, s0, s1;
  isp_pkg::out_t      res;

  always_comb begin
    q0 = (c_prod0 + 34'sd32768) >>> 16;
    q1 = (c_prod1 + 34'sd32768) >>> 16;
    s0 = 34'(c_a0) + q0;
    s1 = 34'(c_a1) + q1;
    res.channels_out   = c_nch;
    res.finished_pulse = c_fin;
    res.sample_ch0     = (c_play && c_nch != 2'd0) ? s0[15:0] : 16'sd0;
    res.sample_ch1     = (c_play && c_nch > 2'd1) ? s1[15:0] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= res;
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("input taken during position reduction");

  a_pos_in_buffer: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ({2'b00, pos} < (SW'(MAX_SAMPLES) << 16)))
    else $error("play position beyond the store");

  a_reduce_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CW'(1)) |=> !busy)
    else $error("position reduction overran");

  a_reduce_from_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(smp_acc))
    else $error("reduction started without a sample word");

  a_stage_b_drains: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_valid) |=> c_valid)
    else $error("word lost between read and multiply stages");

endmodule
